### hdl/sbfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfp_pkg
// Shared types and protocol constants for the serial bus frame parser.
// ----------------------------------------------------------------------------
package sbfp_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] sum_t;

    localparam byte_t HDR_FIRST  = 8'h55;
    localparam byte_t HDR_SECOND = 8'hAA;
    localparam sum_t  SUM_INVERT = 16'hFFFF;
    // length byte counts two bytes that are not payload
    localparam byte_t LEN_BIAS   = 8'd2;

endpackage

### hdl/sbfp_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfp_stream_if
// Valid/ready channels: received bytes in, parsed frame summaries out.
// ----------------------------------------------------------------------------
interface sbfp_byte_if import sbfp_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbfp_frame_if import sbfp_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t dest_addr;
    byte_t command;
    byte_t argument;
    byte_t payload_len;
    sum_t  recv_checksum;
    logic  checksum_ok;

    modport source (output valid, output dest_addr, output command, output argument,
                    output payload_len, output recv_checksum, output checksum_ok,
                    input ready);
    modport sink   (input valid, input dest_addr, input command, input argument,
                    input payload_len, input recv_checksum, input checksum_ok,
                    output ready);
endinterface

### hdl/scooter_bus_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scooter_bus_frame_parser
// Parses 55 AA | len | addr | cmd | arg | payload | csum_lo | csum_hi frames
// from a byte stream and reports one summary item per completed frame.
// ----------------------------------------------------------------------------
//
//  channel | dir | item                      | handshake
//  --------+-----+---------------------------+-----------------------------
//  rx      | in  | one received byte         | valid & ready at rising clk
//  frame   | out | header fields, len, csum  | valid & ready at rising clk
//
//  Flow: one byte per cycle while no result waits unread. An accepted byte
//  is held in the input register, then the parser step writes state and,
//  on the last checksum byte, the result register.
//  Reset: rst_n (async, low) returns the parser to header hunt and empties
//  both registers.
//  Stalls: the input stage holds only while a result waits unread; rx.ready
//  follows frame.ready combinationally.
//
module scooter_bus_frame_parser import sbfp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    sbfp_byte_if.sink      rx,
    sbfp_frame_if.source   frame
);

    // parser phases
    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_HEAD = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_ADDR = 3'd3;
    localparam logic [2:0] PH_CMD  = 3'd4;
    localparam logic [2:0] PH_ARG  = 3'd5;
    localparam logic [2:0] PH_DATA = 3'd6;
    localparam logic [2:0] PH_CRC  = 3'd7;

    // ---------------- input register ----------------
    logic  in_valid_reg;
    byte_t in_byte_reg;

    // ---------------- parser state ----------------
    logic [2:0] phase_reg,      phase_next;
    byte_t      count_reg,      count_next;   // payload count, then csum byte index
    sum_t       sum_reg,        sum_next;
    byte_t      len_reg,        len_next;
    byte_t      addr_reg,       addr_next;
    byte_t      cmd_reg,        cmd_next;
    byte_t      arg_reg,        arg_next;
    byte_t      csum_lo_reg,    csum_lo_next;

    // ---------------- result register ----------------
    logic  out_valid_reg, out_valid_next;
    byte_t out_addr_reg;
    byte_t out_cmd_reg;
    byte_t out_arg_reg;
    byte_t out_len_reg;
    sum_t  out_csum_reg;
    logic  out_ok_reg;

    logic  advance;   // parser consumes the held byte this cycle
    logic  emit;      // held byte closes a frame
    byte_t b;
    sum_t  sum_add;
    sum_t  recv;
    byte_t count_inc;

    // A result can land whenever the output slot is empty or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || frame.ready);
    assign rx.ready = !in_valid_reg || advance;

    assign b         = in_byte_reg;
    assign sum_add   = sum_reg + {8'd0, b};
    assign recv      = {b, csum_lo_reg};
    assign count_inc = count_reg + 8'd1;
    assign emit      = (phase_reg == PH_CRC) && (count_reg != 8'd0);

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        len_next     = len_reg;
        addr_next    = addr_reg;
        cmd_next     = cmd_reg;
        arg_next     = arg_reg;
        csum_lo_next = csum_lo_reg;
        case (phase_reg)
            PH_HUNT:
            begin
                if (b == HDR_FIRST)
                begin
                    phase_next = PH_HEAD;
                end
                count_next = 8'd0;
            end
            PH_HEAD:
            begin
                // a wrong second byte drops back, it is not rechecked as 0x55
                phase_next = (b == HDR_SECOND) ? PH_LEN : PH_HUNT;
            end
            PH_LEN:
            begin
                sum_next   = {8'd0, b};   // sum restarts per frame
                len_next   = (b >= LEN_BIAS) ? (b - LEN_BIAS) : 8'd0;
                count_next = 8'd0;
                phase_next = PH_ADDR;
            end
            PH_ADDR:
            begin
                sum_next   = sum_add;
                addr_next  = b;
                phase_next = PH_CMD;
            end
            PH_CMD:
            begin
                sum_next   = sum_add;
                cmd_next   = b;
                phase_next = PH_ARG;
            end
            PH_ARG:
            begin
                sum_next   = sum_add;
                arg_next   = b;
                count_next = 8'd0;
                phase_next = (len_reg == 8'd0) ? PH_CRC : PH_DATA;
            end
            PH_DATA:
            begin
                sum_next = sum_add;
                if (count_inc >= len_reg)
                begin
                    count_next = 8'd0;
                    phase_next = PH_CRC;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_CRC:
            begin
                // checksum bytes stay out of the sum
                if (count_reg == 8'd0)
                begin
                    csum_lo_next = b;
                    count_next   = 8'd1;
                end
                else
                begin
                    count_next = 8'd0;
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_comb
    begin
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HUNT;
            count_reg     <= 8'd0;
        end
        else
        begin
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (advance)
        begin
            sum_reg     <= sum_next;
            len_reg     <= len_next;
            addr_reg    <= addr_next;
            cmd_reg     <= cmd_next;
            arg_reg     <= arg_next;
            csum_lo_reg <= csum_lo_next;
        end
        if (advance && emit)
        begin
            out_addr_reg <= addr_reg;
            out_cmd_reg  <= cmd_reg;
            out_arg_reg  <= arg_reg;
            out_len_reg  <= len_reg;
            out_csum_reg <= recv;
            out_ok_reg   <= (recv == (sum_reg ^ SUM_INVERT));
        end
    end

    assign frame.valid         = out_valid_reg;
    assign frame.dest_addr     = out_addr_reg;
    assign frame.command       = out_cmd_reg;
    assign frame.argument      = out_arg_reg;
    assign frame.payload_len   = out_len_reg;
    assign frame.recv_checksum = out_csum_reg;
    assign frame.checksum_ok   = out_ok_reg;

endmodule

### hdl/sbfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfp_checker
// Port-level checks on the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module sbfp_checker import sbfp_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  rx_valid,
    input logic  rx_ready,
    input logic  frame_valid,
    input logic  frame_ready,
    input byte_t frame_addr,
    input sum_t  frame_csum
);

    // a waiting result is not withdrawn
    a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> frame_valid)
        else $error("frame item dropped while stalled");

    // a stalled result keeps its fields
    a_frame_stable: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> $stable(frame_addr) && $stable(frame_csum))
        else $error("frame item changed while stalled");

    // input side never blocks while the output side can take a result
    a_rx_open: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_ready || !frame_valid) |-> rx_ready)
        else $error("rx blocked with output free");

    // a fresh result traces back to an accepted byte, via the input register and the parser step
    a_frame_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame_valid) |-> $past(rx_valid && rx_ready, 2))
        else $error("frame item without closing byte");

endmodule

bind scooter_bus_frame_parser sbfp_checker u_sbfp_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .rx_valid    (rx.valid),
    .rx_ready    (rx.ready),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .frame_addr  (frame.dest_addr),
    .frame_csum  (frame.recv_checksum)
);
